/* sv/kct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;

	localparam int unsigned NUM_ENTRIES_DEF = 16;
	localparam int unsigned MAX_TRACKS_DEF  = 32;
	localparam int unsigned KEY_BITS_DEF    = 56;

	// collect keeps at most this many ids
	localparam int unsigned COLLECT_MAX = 64;
	localparam int unsigned CNT_W       = $clog2(COLLECT_MAX + 1);
	localparam int unsigned EMIT_AW     = $clog2(COLLECT_MAX);
	localparam int unsigned MEDIA_W     = 31;

	localparam logic [2:0] FN_LOOKUP     = 3'd0;
	localparam logic [2:0] FN_SET_HEADER = 3'd1;
	localparam logic [2:0] FN_SET_TRACK  = 3'd2;
	localparam logic [2:0] FN_REMOVE     = 3'd3;
	localparam logic [2:0] FN_CLEAR      = 3'd4;
	localparam logic [2:0] FN_COLLECT    = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] CT_PODCAST = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_LK_RD,
		S_LK_DAT,
		S_CO_ENT,
		S_CO_TRD,
		S_CO_TDAT,
		S_CO_CHK,
		S_CO_CDAT,
		S_CO_ORD,
		S_CO_ODAT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         slot;
		logic [7:0]         volume;
		logic [1:0]         card_type;
		logic [5:0]         count;
		logic [5:0]         pos;
		logic [MEDIA_W-1:0] media;
		logic               id_valid;
		logic               last;
	} res_t;

endpackage
`default_nettype wire

/* sv/kct_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module kct_ram #(
	parameter int unsigned AW = 9,
	parameter int unsigned DW = 31
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [0:(1 << AW) - 1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/keyed_card_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Fully associative card table. Each transaction on the input channel runs one
// operation (lookup, set header, set track, remove, clear, collect) and yields
// a run of one or more result transactions, the final one flagged by last;
// every result carries the live entry count after the operation. One sequencer
// drives a single key comparator and one read port on each memory, so the
// block takes one transaction at a time and holds in_stall high until the last
// result of the run has moved into the output register. Key search scans one
// slot per cycle. Set header, set track, remove, a lookup miss and a lookup hit
// on an entry with no tracks pass through scan, execute and the output
// register. A lookup hit on an entry with tracks then reads each track in turn
// (read address, read data, output register). Clear and unknown functions skip
// the scan. Collect visits each entry in turn, reads each track of an eligible
// entry and checks it for duplicates against each id already kept, one compare
// at a time, then emits each kept id (read address, read data, output
// register). A stalled output holds the sequencer in its output state.
module keyed_card_table #(
	parameter int unsigned NUM_ENTRIES = kct_pkg::NUM_ENTRIES_DEF,
	parameter int unsigned MAX_TRACKS  = kct_pkg::MAX_TRACKS_DEF,
	parameter int unsigned KEY_BITS    = kct_pkg::KEY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  func,
	input  wire logic [55:0] key,
	input  wire logic [9:0]  track_total,
	input  wire logic [4:0]  track_index,
	input  wire logic [30:0] media_id,
	input  wire logic [7:0]  volume_in,
	input  wire logic [1:0]  card_type_in,
	input  wire logic [6:0]  id_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       slot,
	output logic [7:0]       volume_out,
	output logic [1:0]       card_type_out,
	output logic [5:0]       track_count_out,
	output logic [5:0]       track_pos,
	output logic [30:0]      media_out,
	output logic             id_valid,
	output logic [4:0]       entry_count,
	output logic             last
);
	import kct_pkg::*;

	localparam int unsigned SW  = $clog2(NUM_ENTRIES);
	localparam int unsigned IW  = SW + 1;
	localparam int unsigned TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);
	localparam int unsigned LW  = $clog2(NUM_ENTRIES + 1);
	localparam int unsigned EW  = SW + MEDIA_W;

	// entry store
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [KEY_BITS-1:0]    ent_key_q    [NUM_ENTRIES];
	logic [7:0]             ent_vol_q    [NUM_ENTRIES];
	logic [1:0]             ent_type_q   [NUM_ENTRIES];
	logic [TCW-1:0]         ent_tracks_q [NUM_ENTRIES];
	logic [LW-1:0]          live_q;

	// latched transaction
	logic [2:0]          func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [9:0]          total_q;
	logic [4:0]          tidx_q;
	logic [MEDIA_W-1:0]  media_q;
	logic [7:0]          vol_q;
	logic [1:0]          ctype_q;
	logic [CNT_W-1:0]    limit_q;

	// sequencer
	state_t           state_q, state_d, ret_q;
	logic [IW-1:0]    scan_q;
	logic [TCW-1:0]   trk_q;
	logic [CNT_W-1:0] cnt_q, k_q;
	logic             hit_q, free_q;
	logic [SW-1:0]    hit_slot_q, free_slot_q;
	logic [MEDIA_W-1:0] cand_q;
	res_t             res_q, out_q;
	logic             out_valid_q;
	logic [LW-1:0]    out_live_q;

	logic [63:0]         key_ext;
	logic [KEY_BITS-1:0] key_m;
	logic [SW-1:0]       idx;
	logic                accept, out_free, scan_last, co_done, eligible, last_trk;
	logic                cnt_full_next, tidx_ok;
	logic [TCW-1:0]      total_sat;
	logic [CNT_W-1:0]    limit_sat;

	logic                trk_we;
	logic [SW+TIW-1:0]   trk_waddr, trk_raddr;
	logic [MEDIA_W-1:0]  trk_rdata;
	logic                emit_we;
	logic [EW-1:0]       emit_rdata;
	logic [SW-1:0]       emit_slot;

	assign key_ext   = 64'(key);
	assign key_m     = key_ext[KEY_BITS-1:0];
	assign idx       = scan_q[SW-1:0];
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_last = idx == SW'(NUM_ENTRIES - 1);
	assign co_done   = (cnt_q == limit_q) || (scan_q == IW'(NUM_ENTRIES));
	assign eligible  = valid_q[idx] && (ent_type_q[idx] != CT_PODCAST)
		&& (ent_tracks_q[idx] != '0);
	assign last_trk  = TCW'(trk_q + 1'b1) == ent_tracks_q[idx];
	assign cnt_full_next = CNT_W'(cnt_q + 1'b1) == limit_q;
	assign tidx_ok   = 32'(tidx_q) < MAX_TRACKS;
	assign total_sat = (32'(total_q) > MAX_TRACKS) ? TCW'(MAX_TRACKS) : TCW'(total_q);
	assign limit_sat = (id_limit > CNT_W'(COLLECT_MAX)) ? CNT_W'(COLLECT_MAX) : id_limit;
	assign emit_slot = emit_rdata[EW-1:MEDIA_W];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (func <= FN_REMOVE) ? S_SCAN : S_EXEC;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (func_q)
					FN_LOOKUP: begin
						state_d = (hit_q && ent_tracks_q[hit_slot_q] != '0) ? S_LK_RD : S_OUT;
					end
					FN_COLLECT: state_d = S_CO_ENT;
					default:    state_d = S_OUT;
				endcase
			end
			S_LK_RD:   state_d = S_LK_DAT;
			S_LK_DAT:  state_d = S_OUT;
			S_CO_ENT: begin
				if (co_done) begin
					state_d = (cnt_q == '0) ? S_OUT : S_CO_ORD;
				end else if (eligible) begin
					state_d = S_CO_TRD;
				end
			end
			S_CO_TRD:  state_d = S_CO_TDAT;
			S_CO_TDAT: state_d = S_CO_CHK;
			S_CO_CHK: begin
				if (k_q == cnt_q) begin
					state_d = (last_trk || cnt_full_next) ? S_CO_ENT : S_CO_TRD;
				end else begin
					state_d = S_CO_CDAT;
				end
			end
			S_CO_CDAT: begin
				if (emit_rdata[MEDIA_W-1:0] == cand_q) begin
					state_d = last_trk ? S_CO_ENT : S_CO_TRD;
				end else begin
					state_d = S_CO_CHK;
				end
			end
			S_CO_ORD:  state_d = S_CO_ODAT;
			S_CO_ODAT: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = res_q.last ? S_IDLE : ret_q;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		in_stall  = state_q != S_IDLE;
		trk_we    = (state_q == S_EXEC) && (func_q == FN_SET_TRACK) && hit_q && tidx_ok;
		trk_waddr = {hit_slot_q, TIW'(tidx_q)};
		trk_raddr = {idx, trk_q[TIW-1:0]};
		if (state_q == S_LK_RD) begin
			trk_raddr = {hit_slot_q, trk_q[TIW-1:0]};
		end
		emit_we = (state_q == S_CO_CHK) && (k_q == cnt_q);
	end

	kct_ram #(.AW(SW + TIW), .DW(MEDIA_W)) u_track_ram (
		.clk   (clk),
		.we    (trk_we),
		.waddr (trk_waddr),
		.wdata (media_q),
		.raddr (trk_raddr),
		.rdata (trk_rdata)
	);

	kct_ram #(.AW(EMIT_AW), .DW(EW)) u_emit_ram (
		.clk   (clk),
		.we    (emit_we),
		.waddr (cnt_q[EMIT_AW-1:0]),
		.wdata ({idx, cand_q}),
		.raddr (k_q[EMIT_AW-1:0]),
		.rdata (emit_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			valid_q     <= '0;
			live_q      <= '0;
			scan_q      <= '0;
			trk_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			hit_slot_q  <= '0;
			free_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// first match and first free slot, one slot a cycle
					if (valid_q[idx] && ent_key_q[idx] == key_q && !hit_q) begin
						hit_q      <= 1'b1;
						hit_slot_q <= idx;
					end
					if (!valid_q[idx] && !free_q) begin
						free_q      <= 1'b1;
						free_slot_q <= idx;
					end
					scan_q <= IW'(scan_q + 1'b1);
				end
				S_EXEC: begin
					trk_q <= '0;
					case (func_q)
						FN_SET_HEADER: begin
							if (!hit_q && free_q) begin
								valid_q[free_slot_q] <= 1'b1;
								live_q <= LW'(live_q + 1'b1);
							end
						end
						FN_REMOVE: begin
							if (hit_q) begin
								valid_q[hit_slot_q] <= 1'b0;
								live_q <= LW'(live_q - 1'b1);
							end
						end
						FN_CLEAR: begin
							valid_q <= '0;
							live_q  <= '0;
						end
						FN_COLLECT: begin
							scan_q <= '0;
							cnt_q  <= '0;
						end
						default: ;
					endcase
				end
				S_LK_DAT: begin
					trk_q <= TCW'(trk_q + 1'b1);
					ret_q <= S_LK_RD;
				end
				S_CO_ENT: begin
					k_q <= '0;
					if (!co_done && !eligible) begin
						scan_q <= IW'(scan_q + 1'b1);
						trk_q  <= '0;
					end
				end
				S_CO_TDAT: k_q <= '0;
				S_CO_CHK: begin
					if (k_q == cnt_q) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						if (last_trk || cnt_full_next) begin
							scan_q <= IW'(scan_q + 1'b1);
							trk_q  <= '0;
						end else begin
							trk_q <= TCW'(trk_q + 1'b1);
						end
					end
				end
				S_CO_CDAT: begin
					if (emit_rdata[MEDIA_W-1:0] == cand_q) begin
						if (last_trk) begin
							scan_q <= IW'(scan_q + 1'b1);
							trk_q  <= '0;
						end else begin
							trk_q <= TCW'(trk_q + 1'b1);
						end
					end else begin
						k_q <= CNT_W'(k_q + 1'b1);
					end
				end
				S_CO_ODAT: begin
					k_q   <= CNT_W'(k_q + 1'b1);
					ret_q <= S_CO_ORD;
				end
				default: ;
			endcase
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			key_q   <= key_m;
			total_q <= track_total;
			tidx_q  <= track_index;
			media_q <= media_id;
			vol_q   <= volume_in;
			ctype_q <= card_type_in;
			limit_q <= limit_sat;
		end
		case (state_q)
			S_EXEC: begin
				res_q      <= '0;
				res_q.last <= 1'b1;
				case (func_q)
					FN_LOOKUP: begin
						if (!hit_q) begin
							res_q.status <= ST_MISS;
						end else begin
							res_q.slot      <= 4'(hit_slot_q);
							res_q.volume    <= ent_vol_q[hit_slot_q];
							res_q.card_type <= ent_type_q[hit_slot_q];
							res_q.count     <= 6'(ent_tracks_q[hit_slot_q]);
						end
					end
					FN_SET_HEADER: begin
						if (hit_q || free_q) begin
							// update in place on a hit, else take the lowest free slot
							ent_key_q[hit_q ? hit_slot_q : free_slot_q]    <= key_q;
							ent_vol_q[hit_q ? hit_slot_q : free_slot_q]    <= vol_q;
							ent_type_q[hit_q ? hit_slot_q : free_slot_q]   <= ctype_q;
							ent_tracks_q[hit_q ? hit_slot_q : free_slot_q] <= total_sat;
							res_q.slot      <= 4'(hit_q ? hit_slot_q : free_slot_q);
							res_q.volume    <= vol_q;
							res_q.card_type <= ctype_q;
							res_q.count     <= 6'(total_sat);
						end else begin
							res_q.status <= ST_FULL;
						end
					end
					FN_SET_TRACK: begin
						if (!hit_q) begin
							res_q.status <= ST_MISS;
						end else begin
							res_q.slot      <= 4'(hit_slot_q);
							res_q.volume    <= ent_vol_q[hit_slot_q];
							res_q.card_type <= ent_type_q[hit_slot_q];
							res_q.count     <= 6'(ent_tracks_q[hit_slot_q]);
							res_q.pos       <= 6'(tidx_q);
							if (tidx_ok) begin
								res_q.media    <= media_q;
								res_q.id_valid <= 1'b1;
							end
						end
					end
					FN_REMOVE: begin
						if (!hit_q) begin
							res_q.status <= ST_MISS;
						end else begin
							res_q.slot <= 4'(hit_slot_q);
						end
					end
					default: ;
				endcase
			end
			S_LK_DAT: begin
				res_q.status    <= ST_OK;
				res_q.slot      <= 4'(hit_slot_q);
				res_q.volume    <= ent_vol_q[hit_slot_q];
				res_q.card_type <= ent_type_q[hit_slot_q];
				res_q.count     <= 6'(ent_tracks_q[hit_slot_q]);
				res_q.pos       <= 6'(trk_q);
				res_q.media     <= trk_rdata;
				res_q.id_valid  <= 1'b1;
				res_q.last      <= TCW'(trk_q + 1'b1) == ent_tracks_q[hit_slot_q];
			end
			S_CO_ENT: begin
				if (co_done && cnt_q == '0) begin
					res_q      <= '0;
					res_q.last <= 1'b1;
				end
			end
			S_CO_TDAT: cand_q <= trk_rdata;
			S_CO_ODAT: begin
				res_q.status    <= ST_OK;
				res_q.slot      <= 4'(emit_slot);
				res_q.volume    <= ent_vol_q[emit_slot];
				res_q.card_type <= ent_type_q[emit_slot];
				res_q.count     <= 6'(k_q + 1'b1);
				res_q.pos       <= 6'(k_q);
				res_q.media     <= emit_rdata[MEDIA_W-1:0];
				res_q.id_valid  <= 1'b1;
				res_q.last      <= CNT_W'(k_q + 1'b1) == cnt_q;
			end
			S_OUT: begin
				if (out_free) begin
					out_q      <= res_q;
					out_live_q <= live_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign slot            = out_q.slot;
	assign volume_out      = out_q.volume;
	assign card_type_out   = out_q.card_type;
	assign track_count_out = out_q.count;
	assign track_pos       = out_q.pos;
	assign media_out       = out_q.media;
	assign id_valid        = out_q.id_valid;
	assign entry_count     = 5'(out_live_q);
	assign last            = out_q.last;

`ifndef SYNTHESIS
	a_live_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) == $countones(valid_q))
		else $error("live count differs from valid bits");
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CO_ENT || state_q == S_CO_CHK) |-> cnt_q <= limit_q)
		else $error("collect kept more ids than the limit");
	a_out_only_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && res_q.last) |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after last result");
`endif
endmodule
`default_nettype wire
